FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during rst.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk and disabled during rst.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/pfe_pkg.sv
package pfe_pkg;

  localparam int COLOUR_W = 12;

  typedef logic [COLOUR_W-1:0] colour_t;

  typedef enum logic [2:0] {
    MODE_WR_CUR    = 3'd0,
    MODE_WR_TGT    = 3'd1,
    MODE_READ      = 3'd2,
    MODE_FILL      = 3'd3,
    MODE_FADE_IN   = 3'd4,
    MODE_FADE_OUT  = 3'd5,
    MODE_WHITE_IN  = 3'd6,
    MODE_WHITE_OUT = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DONE
  } state_t;

  localparam logic REG_FADE_START  = 1'b0;
  localparam logic REG_FADE_LENGTH = 1'b1;

  localparam colour_t STEP_B = 12'h200;
  localparam colour_t STEP_G = 12'h020;
  localparam colour_t STEP_R = 12'h002;
  localparam colour_t CHAN_R = 12'h00E;
  localparam colour_t CHAN_G = 12'h0E0;
  localparam colour_t CHAN_B = 12'hE00;
  localparam colour_t WHITE  = 12'hEEE;

endpackage

FILE: hw/rtl/pfe_if.sv
interface pfe_in_if;
  import pfe_pkg::*;
  logic          valid;
  logic          ready;
  logic [2:0]    mode;
  logic          bank;
  logic [5:0]    index;
  colour_t       colour;

  modport source (output valid, output mode, output bank, output index, output colour,
                  input ready);
  modport sink (input valid, input mode, input bank, input index, input colour,
                output ready);
endinterface

interface pfe_out_if;
  import pfe_pkg::*;
  logic    valid;
  logic    ready;
  colour_t read_colour;

  modport source (output valid, output read_colour, input ready);
  modport sink (input valid, input read_colour, output ready);
endinterface

FILE: hw/rtl/pfe_ram.sv
module pfe_ram #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/pfe_step.sv
module pfe_step
  import pfe_pkg::*;
(
  input  mode_t   kind,
  input  colour_t cur,
  input  colour_t tgt,
  output colour_t nxt
);

  logic [COLOUR_W:0] a;
  logic [COLOUR_W:0] b;

  assign a = {1'b0, cur};
  assign b = {1'b0, tgt};

  always_comb begin
    nxt = cur;
    unique case (kind)
      MODE_FADE_IN: begin
        if (cur == tgt) begin
          nxt = cur;
        end else if (a + {1'b0, STEP_B} <= b) begin
          nxt = cur + STEP_B;
        end else if (a + {1'b0, STEP_G} <= b) begin
          nxt = cur + STEP_G;
        end else if (a + {1'b0, STEP_R} <= b) begin
          nxt = cur + STEP_R;
        end
      end
      MODE_FADE_OUT: begin
        if ((cur & CHAN_R) != '0) begin
          nxt = cur - STEP_R;
        end else if ((cur & CHAN_G) != '0) begin
          nxt = cur - STEP_G;
        end else if ((cur & CHAN_B) != '0) begin
          nxt = cur - STEP_B;
        end
      end
      MODE_WHITE_IN: begin
        if (cur == tgt) begin
          nxt = cur;
        end else if (a >= b + {1'b0, STEP_B}) begin
          nxt = cur - STEP_B;
        end else if (a >= b + {1'b0, STEP_G}) begin
          nxt = cur - STEP_G;
        end else if (a >= b + {1'b0, STEP_R}) begin
          nxt = cur - STEP_R;
        end
      end
      MODE_WHITE_OUT: begin
        if (cur == WHITE) begin
          nxt = cur;
        end else if ((cur & CHAN_R) != CHAN_R) begin
          nxt = cur + STEP_R;
        end else if ((cur & CHAN_G) != CHAN_G) begin
          nxt = cur + STEP_G;
        end else if ((cur & CHAN_B) != CHAN_B) begin
          nxt = cur + STEP_B;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

FILE: hw/rtl/palette_fade_engine.sv
// Writes and reads register the accepted word, execute it and then load the result
// word into the output register; no new word is accepted until that result word is loaded.
// A black fill walks n entries; a fade tick walks n entries in each bank in turn, its pace
// set by the single read and write port of each palette memory, one entry per cycle with
// write-back overlapped. After reset a clearing pass zeroes both memories, accepting no word.
module palette_fade_engine
  import pfe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  pfe_in_if.sink     req,
  pfe_out_if.source  rsp
);

  `include "assert_macros.svh"

  localparam int AW    = $clog2(PALETTE_ENTRIES);
  localparam int RAM_W = AW + 1;
  localparam int CNT_W = ($clog2(PALETTE_ENTRIES + 1) > 8) ? $clog2(PALETTE_ENTRIES + 1) : 8;

  state_t             state;
  state_t             state_next;
  logic [RAM_W-1:0]   clr_cnt;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic               bnk;
  logic               bnk_next;
  logic               rd_vld;
  logic               rd_vld_next;
  logic [RAM_W-1:0]   rd_addr;

  logic [5:0]         fade_start;
  logic [6:0]         fade_length;
  logic [CNT_W-1:0]   range_sum;
  logic [CNT_W-1:0]   range_end;

  mode_t              item_mode;
  logic               item_bank;
  logic [5:0]         item_index;
  colour_t            item_colour;
  logic               idx_ok;
  logic [RAM_W-1:0]   item_addr;

  logic               cur_we;
  logic [RAM_W-1:0]   cur_waddr;
  colour_t            cur_wdata;
  logic               cur_re;
  logic [RAM_W-1:0]   cur_raddr;
  colour_t            cur_rdata;
  logic               tgt_we;
  logic [RAM_W-1:0]   tgt_waddr;
  colour_t            tgt_wdata;
  logic               tgt_re;
  colour_t            tgt_rdata;
  colour_t            step_colour;

  logic               load_out;
  logic               out_valid;
  colour_t            out_colour;
  colour_t            res;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.read_colour = out_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_start  <= '0;
      fade_length <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FADE_START:  fade_start  <= cfg_data[5:0];
        REG_FADE_LENGTH: fade_length <= cfg_data;
        default:         fade_length <= fade_length;
      endcase
    end
  end

  assign range_sum = CNT_W'(fade_start) + CNT_W'(fade_length);
  assign range_end = (range_sum > CNT_W'(PALETTE_ENTRIES)) ? CNT_W'(PALETTE_ENTRIES) : range_sum;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_mode   <= mode_t'(req.mode);
      item_bank   <= req.bank;
      item_index  <= req.index;
      item_colour <= req.colour;
    end
  end

  assign idx_ok    = CNT_W'(item_index) < CNT_W'(PALETTE_ENTRIES);
  assign item_addr = {item_bank, AW'(item_index)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      cnt     <= '0;
      bnk     <= 1'b0;
      rd_vld  <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt + 1'b1;
      cnt     <= cnt_next;
      bnk     <= bnk_next;
      rd_vld  <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= cur_raddr;
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    bnk_next    = bnk;
    rd_vld_next = 1'b0;
    cur_we      = 1'b0;
    cur_waddr   = '0;
    cur_wdata   = '0;
    cur_re      = 1'b0;
    cur_raddr   = '0;
    tgt_we      = 1'b0;
    tgt_waddr   = '0;
    tgt_wdata   = '0;
    tgt_re      = 1'b0;
    load_out    = 1'b0;

    // Write-back of the entry read in the previous cycle.
    if (rd_vld) begin
      cur_we    = 1'b1;
      cur_waddr = rd_addr;
      cur_wdata = step_colour;
    end

    unique case (state)
      S_CLEAR: begin
        cur_we    = 1'b1;
        cur_waddr = clr_cnt;
        tgt_we    = 1'b1;
        tgt_waddr = clr_cnt;
        if (&clr_cnt) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (item_mode)
          MODE_WR_CUR: begin
            cur_we     = idx_ok;
            cur_waddr  = item_addr;
            cur_wdata  = item_colour;
            state_next = S_DONE;
          end
          MODE_WR_TGT: begin
            tgt_we     = idx_ok;
            tgt_waddr  = item_addr;
            tgt_wdata  = item_colour;
            state_next = S_DONE;
          end
          MODE_READ: begin
            cur_re     = 1'b1;
            cur_raddr  = item_addr;
            state_next = S_DONE;
          end
          default: begin
            cnt_next   = CNT_W'(fade_start);
            bnk_next   = 1'b0;
            state_next = S_WALK;
          end
        endcase
      end
      S_WALK: begin
        if (cnt < range_end) begin
          if (item_mode == MODE_FILL) begin
            cur_we    = 1'b1;
            cur_waddr = {1'b0, cnt[AW-1:0]};
          end else begin
            cur_re      = 1'b1;
            tgt_re      = 1'b1;
            cur_raddr   = {bnk, cnt[AW-1:0]};
            rd_vld_next = 1'b1;
          end
          cnt_next = cnt + 1'b1;
        end else if ((item_mode != MODE_FILL) && !bnk) begin
          bnk_next = 1'b1;
          cnt_next = CNT_W'(fade_start);
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  pfe_ram #(
    .ADDR_W (RAM_W),
    .DATA_W (COLOUR_W)
  ) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .re    (cur_re),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  pfe_ram #(
    .ADDR_W (RAM_W),
    .DATA_W (COLOUR_W)
  ) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (tgt_waddr),
    .wdata (tgt_wdata),
    .re    (tgt_re),
    .raddr (cur_raddr),
    .rdata (tgt_rdata)
  );

  pfe_step u_step (
    .kind (item_mode),
    .cur  (cur_rdata),
    .tgt  (tgt_rdata),
    .nxt  (step_colour)
  );

  assign res = ((item_mode == MODE_READ) && idx_ok) ? cur_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_colour <= res;
    end
  end

  `ASSERT_NOW(a_no_accept_in_clear, state == S_CLEAR, !req.ready, "word accepted during clear")
  `ASSERT_NOW(a_wb_from_walk, rd_vld, $past(state) == S_WALK, "write-back outside a tick walk")
  `ASSERT_NEXT(a_done_loads, state == S_DONE && (!out_valid || rsp.ready),
               rsp.valid && state == S_IDLE, "finished word not presented")

endmodule

FILE: tb/sv/tb_palette_fade_engine.sv
module tb_palette_fade_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  localparam int ENTRIES = 64;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 123;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    mode_t   mode;
    logic    bank;
    logic [5:0] index;
    colour_t colour;
    logic    fixed;
    colour_t want;
  } plan_row_t;

  localparam int PLAN_ROWS = 24;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [6:0] cfg_data;

  pfe_in_if  req ();
  pfe_out_if rsp ();

  palette_fade_engine #(.PALETTE_ENTRIES(ENTRIES)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  colour_t cur_pal [2][ENTRIES];
  colour_t tgt_pal [2][ENTRIES];
  int      range_start;
  int      range_length;

  colour_t pending_colours[$];
  int      mismatches;
  int      words_sent;
  int      words_checked;
  int      ticks_sent;
  int      fills_sent;
  int      reads_sent;
  int      steady_left;

  plan_row_t plan [PLAN_ROWS];

  localparam int START_SET [PHASES] = '{0, 0, 63, 63, 0, 32, 17, 1, 40, 0};
  localparam int LENGTH_SET [PHASES] = '{64, 0, 1, 64, 1, 64, 5, 63, 0, 64};

  function automatic colour_t fade_step(mode_t m, colour_t v, colour_t t);
    int a;
    int b;
    a = int'(v);
    b = int'(t);
    case (m)
      MODE_FADE_IN: begin
        if (a != b) begin
          if (a + int'(STEP_B) <= b) a += int'(STEP_B);
          else if (a + int'(STEP_G) <= b) a += int'(STEP_G);
          else if (a + int'(STEP_R) <= b) a += int'(STEP_R);
        end
      end
      MODE_FADE_OUT: begin
        if (a != 0) begin
          if ((a & int'(CHAN_R)) != 0) a -= int'(STEP_R);
          else if ((a & int'(CHAN_G)) != 0) a -= int'(STEP_G);
          else if ((a & int'(CHAN_B)) != 0) a -= int'(STEP_B);
        end
      end
      MODE_WHITE_IN: begin
        if (a != b) begin
          if (a >= b + int'(STEP_B)) a -= int'(STEP_B);
          else if (a >= b + int'(STEP_G)) a -= int'(STEP_G);
          else if (a >= b + int'(STEP_R)) a -= int'(STEP_R);
        end
      end
      default: begin
        if (a != int'(WHITE)) begin
          if ((a & int'(CHAN_R)) != int'(CHAN_R)) a += int'(STEP_R);
          else if ((a & int'(CHAN_G)) != int'(CHAN_G)) a += int'(STEP_G);
          else if ((a & int'(CHAN_B)) != int'(CHAN_B)) a += int'(STEP_B);
        end
      end
    endcase
    return colour_t'(a[11:0]);
  endfunction

  function automatic colour_t predict_word(mode_t m, logic b, logic [5:0] idx, colour_t c);
    colour_t r;
    int last;
    r = '0;
    last = range_start + range_length;
    if (last > ENTRIES) last = ENTRIES;
    case (m)
      MODE_WR_CUR: cur_pal[b][idx] = c;
      MODE_WR_TGT: tgt_pal[b][idx] = c;
      MODE_READ:   r = cur_pal[b][idx];
      MODE_FILL: begin
        for (int i = range_start; i < last; i++) cur_pal[0][i] = '0;
      end
      default: begin
        for (int bk = 0; bk < 2; bk++) begin
          for (int i = range_start; i < last; i++) begin
            cur_pal[bk][i] = fade_step(m, cur_pal[bk][i], tgt_pal[bk][i]);
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic colour_t pick_colour();
    case ($urandom_range(0, 5))
      0: return colour_t'($urandom_range(0, 4095));
      1: return colour_t'($urandom_range(0, 4095)) & WHITE;
      2: return '0;
      3: return WHITE;
      4: return 12'hFFF;
      default: return WHITE | (colour_t'($urandom_range(0, 4095)) & 12'h111);
    endcase
  endfunction

  function automatic logic [5:0] pick_index();
    int i;
    if (range_length > 0 && $urandom_range(0, 1) == 1) begin
      i = range_start + $urandom_range(0, range_length - 1);
      if (i > ENTRIES - 1) i = ENTRIES - 1;
      return 6'(i);
    end
    return 6'($urandom_range(0, ENTRIES - 1));
  endfunction

  task automatic send_word(mode_t m, logic b, logic [5:0] idx, colour_t c,
                           logic fixed, colour_t want);
    int gap;
    colour_t w;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.mode   <= m;
    req.bank   <= b;
    req.index  <= idx;
    req.colour <= c;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    w = predict_word(m, b, idx, c);
    pending_colours.push_back(fixed ? want : w);
    words_sent++;
    case (m)
      MODE_READ: reads_sent++;
      MODE_FILL: fills_sent++;
      MODE_WR_CUR, MODE_WR_TGT: ;
      default: ticks_sent++;
    endcase
  endtask

  task automatic send_random(mode_t m);
    send_word(m, 1'($urandom_range(0, 1)), pick_index(), pick_colour(), 1'b0, '0);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
  endtask

  task automatic set_range(int start, int length);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FADE_START;
    cfg_data  <= 7'(start);
    @(posedge clk);
    range_start = start;
    cfg_index <= REG_FADE_LENGTH;
    cfg_data  <= 7'(length);
    @(posedge clk);
    range_length = length;
    cfg_we <= 1'b0;
  endtask

  task automatic note_failure(string what, colour_t want, colour_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("Mismatch: %s, expected %03h, got %03h", what, want, got);
    end
  endtask

  always @(posedge clk) begin
    colour_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_colours.size() == 0) begin
        note_failure("word with nothing expected", '0, rsp.read_colour);
      end else begin
        want = pending_colours.pop_front();
        words_checked++;
        if (rsp.read_colour !== want) note_failure("read_colour", want, rsp.read_colour);
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        case ($urandom_range(0, 19))
          0:       begin rsp.ready <= 1'b1; hold = $urandom_range(100, 300); end
          1:       begin rsp.ready <= 1'b0; hold = $urandom_range(20, 60); end
          2, 3, 4, 5, 6, 7:
                   begin rsp.ready <= 1'b0; hold = $urandom_range(0, 3); end
          default: begin rsp.ready <= 1'b1; hold = $urandom_range(0, 20); end
        endcase
      end
    end
  end

  initial begin
    #12_000_000;
    $display("Timeout with %0d words still expected.", pending_colours.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int sent_goal;
    int r;
    int n;
    mode_t kind;

    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_FADE_START;
    cfg_data   <= '0;
    req.valid  <= 1'b0;
    req.mode   <= MODE_READ;
    req.bank   <= 1'b0;
    req.index  <= '0;
    req.colour <= '0;

    for (int bk = 0; bk < 2; bk++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        cur_pal[bk][i] = '0;
        tgt_pal[bk][i] = '0;
      end
    end
    range_start   = 0;
    range_length  = 64;
    mismatches    = 0;
    words_sent    = 0;
    words_checked = 0;
    ticks_sent    = 0;
    fills_sent    = 0;
    reads_sent    = 0;
    steady_left   = 0;

    // Stray-bit words, a saturated word that is not white, and fades toward black and white.
    plan = '{
      '{MODE_READ,      1'b0, 6'd0,  12'h000, 1'b1, 12'h000},
      '{MODE_READ,      1'b1, 6'd63, 12'hFFF, 1'b1, 12'h000},
      '{MODE_WR_CUR,    1'b0, 6'd0,  12'hFFF, 1'b1, 12'h000},
      '{MODE_READ,      1'b0, 6'd0,  12'h000, 1'b1, 12'hFFF},
      '{MODE_WR_CUR,    1'b1, 6'd63, 12'h000, 1'b1, 12'h000},
      '{MODE_WR_CUR,    1'b0, 6'd1,  12'h111, 1'b1, 12'h000},
      '{MODE_FADE_OUT,  1'b1, 6'd9,  12'h5A5, 1'b1, 12'h000},
      '{MODE_READ,      1'b0, 6'd1,  12'h000, 1'b1, 12'h111},
      '{MODE_READ,      1'b0, 6'd0,  12'h000, 1'b0, 12'h000},
      '{MODE_WR_TGT,    1'b0, 6'd2,  12'hEEE, 1'b1, 12'h000},
      '{MODE_WR_CUR,    1'b0, 6'd2,  12'h000, 1'b1, 12'h000},
      '{MODE_FADE_IN,   1'b0, 6'd33, 12'hABC, 1'b1, 12'h000},
      '{MODE_READ,      1'b0, 6'd2,  12'h000, 1'b0, 12'h000},
      '{MODE_WR_CUR,    1'b1, 6'd3,  12'hEEF, 1'b1, 12'h000},
      '{MODE_WHITE_OUT, 1'b0, 6'd0,  12'h000, 1'b1, 12'h000},
      '{MODE_READ,      1'b1, 6'd3,  12'h000, 1'b1, 12'hEEF},
      '{MODE_WR_TGT,    1'b1, 6'd4,  12'h000, 1'b1, 12'h000},
      '{MODE_WR_CUR,    1'b1, 6'd4,  12'hFFF, 1'b1, 12'h000},
      '{MODE_WHITE_IN,  1'b1, 6'd63, 12'hFFF, 1'b1, 12'h000},
      '{MODE_READ,      1'b1, 6'd4,  12'h000, 1'b0, 12'h000},
      '{MODE_FILL,      1'b1, 6'd5,  12'h777, 1'b1, 12'h000},
      '{MODE_READ,      1'b0, 6'd0,  12'h000, 1'b1, 12'h000},
      '{MODE_READ,      1'b1, 6'd0,  12'h000, 1'b0, 12'h000},
      '{MODE_READ,      1'b1, 6'd63, 12'h000, 1'b0, 12'h000}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int row = 0; row < PLAN_ROWS; row++) begin
      send_word(plan[row].mode, plan[row].bank, plan[row].index, plan[row].colour,
                plan[row].fixed, plan[row].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p > 0) set_range(START_SET[p], LENGTH_SET[p]);
      sent_goal = words_sent + WORDS_PER_PHASE;
      while (words_sent < sent_goal) begin
        r = $urandom_range(0, 99);
        if (r < 14) begin
          kind = mode_t'($urandom_range(4, 7));
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24) : $urandom_range(2, 8);
          repeat ($urandom_range(0, 3)) send_random(MODE_WR_TGT);
          repeat (n) send_random(kind);
          repeat (3) send_random(MODE_READ);
        end else if (r < 16) begin
          wait_drained();
        end else begin
          r = $urandom_range(0, 99);
          if (r < 22) send_random(MODE_WR_CUR);
          else if (r < 38) send_random(MODE_WR_TGT);
          else if (r < 68) send_random(MODE_READ);
          else if (r < 70) send_random(MODE_FILL);
          else send_random(mode_t'($urandom_range(4, 7)));
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_colours.size() != 0) note_failure("expected word never came", '0, '0);

    $display("Sent %0d words over %0d fade ranges: %0d fade ticks, %0d black fills, %0d reads.",
             words_sent, PHASES, ticks_sent, fills_sent, reads_sent);
    $display("Checked %0d result words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
